// ===== src/tlik_pkg.sv =====
// Shared types and constants for the two-link inverse kinematics pipeline.
`timescale 1ns / 1ps

package tlik_pkg;

  // Working width of the CORDIC datapath (Q2.30 angles and normalized operands).
  localparam int CW = 36;
  localparam int ATAN_LEN = 24;
  localparam int NORM_STAGES = 6;

  typedef logic signed [CW-1:0] cw_t;

  localparam cw_t HALF_PI_Q30 = 36'sd1686629713;

  localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128
  };

  typedef enum logic [2:0] {
    REG_FIRST_LEN  = 3'd0,
    REG_SECOND_LEN = 3'd1,
    REG_FIRST_MIN  = 3'd2,
    REG_FIRST_MAX  = 3'd3,
    REG_SECOND_MIN = 3'd4,
    REG_SECOND_MAX = 3'd5
  } cfg_reg_e;

endpackage

// ===== src/tlik_isqrt.sv =====
// Pipelined integer floor square root, one result bit per stage.
`timescale 1ns / 1ps

module tlik_isqrt #(
  parameter int W  = 32,
  parameter int SW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [W-1:0]    val_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [W/2-1:0]  root_o,
  output logic [SW-1:0]   side_o
);

  localparam int HW = W / 2;

  logic [W-1:0]  rem_q  [HW];
  logic [HW-1:0] root_q [HW];
  logic [SW-1:0] side_q [HW];
  logic [HW-1:0] vld_q;

  genvar s;
  for (s = 0; s < HW; s++) begin : g_stage
    localparam int K = HW - 1 - s;
    logic [W-1:0]  rem_in;
    logic [HW-1:0] root_in;
    logic [SW-1:0] side_in;
    logic          v_in;
    logic [W:0]    test;

    if (s == 0) begin : g_first
      assign rem_in  = val_i;
      assign root_in = '0;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign side_in = side_q[s-1];
      assign v_in    = vld_q[s-1];
    end

    // (root + 2^K)^2 - root^2 = root * 2^(K+1) + 2^(2K)
    assign test = ((W+1)'(root_in) << (K + 1)) + ((W+1)'(1) << (2 * K));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= side_in;
        if ({1'b0, rem_in} >= test) begin
          rem_q[s]  <= rem_in - test[W-1:0];
          root_q[s] <= root_in | (HW'(1) << K);
        end else begin
          rem_q[s]  <= rem_in;
          root_q[s] <= root_in;
        end
      end
    end
  end

  assign valid_o = vld_q[HW-1];
  assign root_o  = root_q[HW-1];
  assign side_o  = side_q[HW-1];

endmodule

// ===== src/tlik_atan2.sv =====
// Pipelined vectoring CORDIC atan2 with operand normalization and half-plane fold.
`timescale 1ns / 1ps

module tlik_atan2 import tlik_pkg::*; #(
  parameter int STEPS = 16,
  parameter int SW    = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  cw_t           y_i,
  input  cw_t           x_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output cw_t           angle_o,
  output logic [SW-1:0] side_o
);

  localparam int NIT  = (STEPS > ATAN_LEN) ? ATAN_LEN : STEPS;
  localparam int FOLD = NORM_STAGES + 1;
  localparam int NS   = FOLD + 1 + NIT;

  cw_t           x_q    [NS];
  cw_t           y_q    [NS];
  cw_t           z_q    [NS];
  logic [SW-1:0] side_q [NS];
  logic [NS-1:0] vld_q;
  logic [NS-1:0] zero_q;

  function automatic logic mag_below(cw_t v, int t);
    logic [CW-1:0] m;
    m = v[CW-1] ? logic'(1'b0) ? '0 : -v : v;
    return m < ({{(CW-1){1'b0}}, 1'b1} << t);
  endfunction

  genvar s;
  for (s = 0; s < NS; s++) begin : g_stage
    cw_t           xn;
    cw_t           yn;
    cw_t           zn;
    logic          zero_n;
    logic          v_n;
    logic [SW-1:0] side_n;

    if (s == 0) begin : g_in
      assign xn     = x_i;
      assign yn     = y_i;
      assign zn     = '0;
      assign zero_n = (x_i == '0) && (y_i == '0);
      assign v_n    = valid_i;
      assign side_n = side_i;
    end else begin : g_work
      assign zero_n = zero_q[s-1];
      assign v_n    = vld_q[s-1];
      assign side_n = side_q[s-1];

      if (s <= NORM_STAGES) begin : g_norm
        // Shift by B only if the larger magnitude stays below 2^33 afterwards.
        localparam int B = 1 << (NORM_STAGES - s);
        logic fit;
        assign fit = mag_below(x_q[s-1], 33 - B) && mag_below(y_q[s-1], 33 - B);
        assign xn  = fit ? (x_q[s-1] <<< B) : x_q[s-1];
        assign yn  = fit ? (y_q[s-1] <<< B) : y_q[s-1];
        assign zn  = z_q[s-1];
      end else if (s == FOLD) begin : g_fold
        always_comb begin
          xn = x_q[s-1];
          yn = y_q[s-1];
          zn = z_q[s-1];
          if (x_q[s-1][CW-1]) begin
            if (!y_q[s-1][CW-1]) begin
              xn = y_q[s-1];
              yn = -x_q[s-1];
              zn = HALF_PI_Q30;
            end else begin
              xn = -y_q[s-1];
              yn = x_q[s-1];
              zn = -HALF_PI_Q30;
            end
          end
        end
      end else begin : g_iter
        localparam int I = s - FOLD - 1;
        cw_t dx;
        cw_t dy;
        assign dx = x_q[s-1] >>> I;
        assign dy = y_q[s-1] >>> I;
        always_comb begin
          if (!y_q[s-1][CW-1]) begin
            xn = x_q[s-1] + dy;
            yn = y_q[s-1] - dx;
            zn = z_q[s-1] + cw_t'(ATAN_Q30[I]);
          end else begin
            xn = x_q[s-1] - dy;
            yn = y_q[s-1] + dx;
            zn = z_q[s-1] - cw_t'(ATAN_Q30[I]);
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= v_n;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[s]    <= xn;
        y_q[s]    <= yn;
        z_q[s]    <= zn;
        zero_q[s] <= zero_n;
        side_q[s] <= side_n;
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign angle_o = zero_q[NS-1] ? '0 : z_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

// ===== src/two_link_inverse_kinematics_unit.sv =====
// Top level of the two-link planar inverse kinematics pipeline.
//
//   channel  direction  handshake            payload
//   in       input      in_valid_i/in_stall_o  target_x_i, target_z_i
//   out      output     out_valid_o/out_stall_i solution_ok_o, first_angle_o, second_angle_o
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One point enters per cycle while in_stall_o is low; the path runs through the 16-stage and
// 32-stage square roots and the CORDIC stages.
// Reset restores the default link lengths and angle limits and empties the pipeline.
// A stall on the output fills a skid register; the pipeline then holds until it drains.
// Configuration writes are always taken and should only occur while no point is in flight.
`timescale 1ns / 1ps

module two_link_inverse_kinematics_unit import tlik_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] target_x_i,
  input  logic signed [15:0] target_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               solution_ok_o,
  output logic signed [15:0] first_angle_o,
  output logic signed [15:0] second_angle_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int QW = CW - 17;

  // Configuration registers.
  logic [14:0]        l1_q;
  logic [14:0]        l2_q;
  logic signed [15:0] min1_q;
  logic signed [15:0] max1_q;
  logic signed [15:0] min2_q;
  logic signed [15:0] max2_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q   <= 15'd12288;
      l2_q   <= 15'd6144;
      min1_q <= -16'sd25736;
      max1_q <= 16'sd25736;
      min2_q <= -16'sd25736;
      max2_q <= 16'sd25736;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FIRST_LEN:  l1_q   <= cfg_data_i[14:0];
        REG_SECOND_LEN: l2_q   <= cfg_data_i[14:0];
        REG_FIRST_MIN:  min1_q <= $signed(cfg_data_i);
        REG_FIRST_MAX:  max1_q <= $signed(cfg_data_i);
        REG_SECOND_MIN: min2_q <= $signed(cfg_data_i);
        REG_SECOND_MAX: max2_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Terms that depend only on the link lengths, refreshed every cycle.
  logic [15:0]        sum_l;
  logic signed [15:0] dif_l;
  logic signed [31:0] difsq_full;
  logic [29:0]        l1sq_q;
  logic [29:0]        l2sq_q;
  logic [31:0]        sumsq_q;
  logic [29:0]        difsq_q;
  logic [31:0]        den2_q;
  logic [15:0]        l1x2_q;
  logic [63:0]        den2sq_q;

  assign sum_l      = {1'b0, l1_q} + {1'b0, l2_q};
  assign dif_l      = $signed({1'b0, l1_q}) - $signed({1'b0, l2_q});
  assign difsq_full = dif_l * dif_l;

  always_ff @(posedge clk_i) begin
    l1sq_q   <= l1_q * l1_q;
    l2sq_q   <= l2_q * l2_q;
    sumsq_q  <= sum_l * sum_l;
    difsq_q  <= difsq_full[29:0];
    den2_q   <= {l1_q, 1'b0} * {1'b0, l2_q};
    l1x2_q   <= {l1_q, 1'b0};
    den2sq_q <= den2_q * den2_q;
  end

  // Output register plus skid register; the pipeline advances while the skid is empty.
  logic en;
  logic skid_q;

  assign en         = !skid_q;
  assign in_stall_o = skid_q;

  // Stage A: input capture.
  logic               va_q;
  logic signed [15:0] xa_q;
  logic signed [15:0] za_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xa_q <= target_x_i;
      za_q <= target_z_i;
    end
  end

  // Stage B: squared distance.
  logic signed [31:0] xx;
  logic signed [31:0] zz;
  logic               vb_q;
  logic signed [15:0] xb_q;
  logic signed [15:0] zb_q;
  logic [31:0]        d2b_q;

  assign xx = xa_q * xa_q;
  assign zz = za_q * za_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xb_q  <= xa_q;
      zb_q  <= za_q;
      d2b_q <= $unsigned(xx) + $unsigned(zz);
    end
  end

  // Reach test runs beside the distance square root.
  logic        ok_reach;
  logic        vc;
  logic [15:0] dc;
  logic [64:0] side_c;

  assign ok_reach = (d2b_q != '0) && (d2b_q <= sumsq_q) && ({2'b0, difsq_q} <= d2b_q);

  tlik_isqrt #(.W(32), .SW(65)) u_dist_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vb_q),
    .val_i   (d2b_q),
    .side_i  ({xb_q, zb_q, d2b_q, ok_reach}),
    .valid_o (vc),
    .root_o  (dc),
    .side_o  (side_c)
  );

  // Stage D: law-of-cosines numerators and first denominator.
  logic               vd_q;
  logic               okd_q;
  logic signed [15:0] xd_q;
  logic signed [15:0] zd_q;
  logic signed [33:0] n1d_q;
  logic signed [33:0] n2d_q;
  logic [31:0]        den1d_q;
  logic signed [33:0] l1sq_s;
  logic signed [33:0] l2sq_s;
  logic signed [33:0] d2c_s;

  assign l1sq_s = $signed({4'b0, l1sq_q});
  assign l2sq_s = $signed({4'b0, l2sq_q});
  assign d2c_s  = $signed({2'b0, side_c[32:1]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en) begin
      vd_q <= vc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xd_q    <= $signed(side_c[64:49]);
      zd_q    <= $signed(side_c[48:33]);
      okd_q   <= side_c[0];
      n1d_q   <= l1sq_s + d2c_s - l2sq_s;
      n2d_q   <= l1sq_s + l2sq_s - d2c_s;
      den1d_q <= l1x2_q * dc;
    end
  end

  // Stage E: cosine range test and squares for the sine terms.
  logic [33:0]        mag1;
  logic [33:0]        mag2;
  logic               ok_cos;
  logic               ve_q;
  logic               oke_q;
  logic signed [15:0] xe_q;
  logic signed [15:0] ze_q;
  logic signed [33:0] n1e_q;
  logic signed [33:0] n2e_q;
  logic [63:0]        den1sq_q;
  logic [63:0]        n1sq_q;
  logic [63:0]        n2sq_q;

  assign mag1   = n1d_q[33] ? $unsigned(-n1d_q) : $unsigned(n1d_q);
  assign mag2   = n2d_q[33] ? $unsigned(-n2d_q) : $unsigned(n2d_q);
  assign ok_cos = (den1d_q != '0) && (den2_q != '0) &&
                  (mag1 <= {2'b0, den1d_q}) && (mag2 <= {2'b0, den2_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else if (en) begin
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      oke_q    <= okd_q && ok_cos;
      xe_q     <= xd_q;
      ze_q     <= zd_q;
      n1e_q    <= n1d_q;
      n2e_q    <= n2d_q;
      den1sq_q <= den1d_q * den1d_q;
      n1sq_q   <= mag1[31:0] * mag1[31:0];
      n2sq_q   <= mag2[31:0] * mag2[31:0];
    end
  end

  // Stage F: D*D - N*N.
  logic               vf_q;
  logic               okf_q;
  logic signed [15:0] xf_q;
  logic signed [15:0] zf_q;
  logic signed [33:0] n1f_q;
  logic signed [33:0] n2f_q;
  logic [63:0]        r1f_q;
  logic [63:0]        r2f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (en) begin
      vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      okf_q <= oke_q;
      xf_q  <= xe_q;
      zf_q  <= ze_q;
      n1f_q <= n1e_q;
      n2f_q <= n2e_q;
      r1f_q <= den1sq_q - n1sq_q;
      r2f_q <= den2sq_q - n2sq_q;
    end
  end

  // Sine terms of both angles.
  logic         vg1;
  logic         vg2;
  logic [31:0]  s1g;
  logic [31:0]  s2g;
  logic [100:0] side_g;
  logic         ok_g2;

  tlik_isqrt #(.W(64), .SW(101)) u_sin1_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vf_q),
    .val_i   (r1f_q),
    .side_i  ({xf_q, zf_q, n1f_q, n2f_q, okf_q}),
    .valid_o (vg1),
    .root_o  (s1g),
    .side_o  (side_g)
  );

  tlik_isqrt #(.W(64), .SW(1)) u_sin2_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vf_q),
    .val_i   (r2f_q),
    .side_i  (okf_q),
    .valid_o (vg2),
    .root_o  (s2g),
    .side_o  (ok_g2)
  );

  logic signed [15:0] xg;
  logic signed [15:0] zg;
  logic signed [33:0] n1g;
  logic signed [33:0] n2g;
  logic               ok_g;

  assign xg   = $signed(side_g[100:85]);
  assign zg   = $signed(side_g[84:69]);
  assign n1g  = $signed(side_g[68:35]);
  assign n2g  = $signed(side_g[34:1]);
  assign ok_g = side_g[0] && ok_g2;

  // Three atan2 units in parallel.
  logic vh1;
  logic vh2;
  logic vh3;
  logic okh1;
  logic okh2;
  logic okh3;
  cw_t  elev_h;
  cw_t  acos1_h;
  cw_t  ang2_h;

  tlik_atan2 #(.STEPS(CORDIC_STEPS), .SW(1)) u_elev (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vg1),
    .y_i     (cw_t'(zg)),
    .x_i     (cw_t'(xg)),
    .side_i  (ok_g),
    .valid_o (vh1),
    .angle_o (elev_h),
    .side_o  (okh1)
  );

  tlik_atan2 #(.STEPS(CORDIC_STEPS), .SW(1)) u_acos1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vg1),
    .y_i     (cw_t'({1'b0, s1g})),
    .x_i     (cw_t'(n1g)),
    .side_i  (ok_g),
    .valid_o (vh2),
    .angle_o (acos1_h),
    .side_o  (okh2)
  );

  tlik_atan2 #(.STEPS(CORDIC_STEPS), .SW(1)) u_ang2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vg2),
    .y_i     (cw_t'({1'b0, s2g})),
    .x_i     (-cw_t'(n2g)),
    .side_i  (ok_g),
    .valid_o (vh3),
    .angle_o (ang2_h),
    .side_o  (okh3)
  );

  // Stage I: Q2.30 to Q3.13 with round half up.
  cw_t                a1_full;
  cw_t                a2_full;
  logic               vi_q;
  logic               oki_q;
  logic signed [QW-1:0] a1i_q;
  logic signed [QW-1:0] a2i_q;

  assign a1_full = (elev_h - acos1_h) + cw_t'(65536);
  assign a2_full = ang2_h + cw_t'(65536);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vi_q <= 1'b0;
    end else if (en) begin
      vi_q <= vh1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      oki_q <= okh1 && okh2 && okh3;
      a1i_q <= $signed(a1_full[CW-1:17]);
      a2i_q <= $signed(a2_full[CW-1:17]);
    end
  end

  function automatic logic signed [15:0] clamp_angle(logic signed [QW-1:0] v,
                                                     logic signed [15:0] lo,
                                                     logic signed [15:0] hi);
    if (v < QW'(lo)) begin
      return lo;
    end else if (v > QW'(hi)) begin
      return hi;
    end
    return v[15:0];
  endfunction

  logic signed [15:0] r_a1;
  logic signed [15:0] r_a2;

  assign r_a1 = oki_q ? clamp_angle(a1i_q, min1_q, max1_q) : '0;
  assign r_a2 = oki_q ? clamp_angle(a2i_q, min2_q, max2_q) : '0;

  // Output register and skid register.
  logic               out_q;
  logic               ok_out_q;
  logic signed [15:0] a1_out_q;
  logic signed [15:0] a2_out_q;
  logic               ok_skid_q;
  logic signed [15:0] a1_skid_q;
  logic signed [15:0] a2_skid_q;
  logic               take;
  logic               load_out;
  logic               load_skid;

  assign take      = out_q && !out_stall_i;
  assign load_out  = skid_q ? take : (vi_q && (!out_q || take));
  assign load_skid = !skid_q && vi_q && out_q && !take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q  <= 1'b0;
      skid_q <= 1'b0;
    end else begin
      if (skid_q) begin
        if (take) begin
          skid_q <= 1'b0;
        end
      end else begin
        if (load_skid) begin
          skid_q <= 1'b1;
        end
        if (vi_q) begin
          out_q <= 1'b1;
        end else if (take) begin
          out_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (skid_q) begin
        ok_out_q <= ok_skid_q;
        a1_out_q <= a1_skid_q;
        a2_out_q <= a2_skid_q;
      end else begin
        ok_out_q <= oki_q;
        a1_out_q <= r_a1;
        a2_out_q <= r_a2;
      end
    end
    if (load_skid) begin
      ok_skid_q <= oki_q;
      a1_skid_q <= r_a1;
      a2_skid_q <= r_a2;
    end
  end

  assign out_valid_o    = out_q;
  assign solution_ok_o  = ok_out_q;
  assign first_angle_o  = a1_out_q;
  assign second_angle_o = a2_out_q;

  // A transaction waits in the skid register only behind a full output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_q |-> out_q)
    else $error("skid register holds data while output register is empty");

  // The two sine square roots run in lockstep.
  assert property (@(posedge clk_i) disable iff (!rst_ni) vg1 == vg2)
    else $error("sine square root pipelines out of step");

  // The three atan2 units run in lockstep.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (vh1 == vh2) && (vh1 == vh3))
    else $error("atan2 pipelines out of step");

  // An unsolvable target reports zero angles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && !solution_ok_o) |->
                   ((first_angle_o == '0) && (second_angle_o == '0)))
    else $error("invalid solution carries nonzero angles");

endmodule

// ===== tb/sv/two_link_inverse_kinematics_unit_test.sv =====
// Self-checking testbench for the two-link inverse kinematics pipeline.
`timescale 1ns / 1ps

module two_link_inverse_kinematics_unit_test;
  import tlik_pkg::*;

  localparam int STEPS = 16;
  localparam int RUN_STEPS = (STEPS < ATAN_LEN) ? STEPS : ATAN_LEN;
  localparam int DRAIN_CYCLES = 63 + RUN_STEPS + 40;
  localparam int STUCK_LIMIT = 20000;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] z;
  } target_t;

  typedef struct packed {
    logic               ok;
    logic signed [15:0] a1;
    logic signed [15:0] a2;
  } joint_solution_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [15:0] target_x_i;
  logic signed [15:0] target_z_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               solution_ok_o;
  logic signed [15:0] first_angle_o;
  logic signed [15:0] second_angle_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [15:0]        cfg_data_i;

  two_link_inverse_kinematics_unit #(.CORDIC_STEPS(STEPS)) u_top (.*);

  target_t         pending_targets[$];
  joint_solution_t expected_solutions[$];

  // Shadow copy of the configuration registers.
  logic [14:0]        link1_len, link2_len;
  logic signed [15:0] a1_lo, a1_hi, a2_lo, a2_hi;

  int send_idle_pct, recv_idle_pct;
  int long_hold_req, long_hold_seen, long_hold_left;
  int fail_count, stuck_cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic bit [63:0] floor_root(bit [63:0] v);
    bit [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic bit [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Vectoring CORDIC, result in Q2.30 radians.
  function automatic longint cordic_angle(longint y, longint x);
    bit [63:0] m;
    longint    ang, t, dx, dy;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    m = (magnitude(x) > magnitude(y)) ? magnitude(x) : magnitude(y);
    while (m < (64'd1 << 32)) begin
      x = x * 2;
      y = y * 2;
      m = m << 1;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        ang = longint'(HALF_PI_Q30);
      end else begin
        x = -y;
        y = t;
        ang = -longint'(HALF_PI_Q30);
      end
    end
    for (int i = 0; i < RUN_STEPS; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y >= 0) begin
        x = x + dy;
        y = y - dx;
        ang = ang + longint'(ATAN_Q30[i]);
      end else begin
        x = x - dy;
        y = y + dx;
        ang = ang - longint'(ATAN_Q30[i]);
      end
    end
    return ang;
  endfunction

  function automatic longint to_q13(longint a);
    return (a + 65536) >>> 17;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic joint_solution_t solve_arm(target_t tg);
    joint_solution_t r;
    longint    x, z, l1, l2, d2, d, n1, n2, a1, a2, elev;
    bit [63:0] den1, den2, s1, s2;
    bit        ok;
    r = '0;
    x = tg.x;
    z = tg.z;
    l1 = link1_len;
    l2 = link2_len;
    d2 = x * x + z * z;
    ok = !(d2 == 0 || d2 > (l1 + l2) * (l1 + l2) || d2 < (l1 - l2) * (l1 - l2));
    d = longint'(floor_root(64'(d2)));
    n1 = l1 * l1 + d2 - l2 * l2;
    den1 = 64'(2 * l1 * d);
    n2 = l1 * l1 + l2 * l2 - d2;
    den2 = 64'(2 * l1 * l2);
    if (den1 == 0 || den2 == 0 || magnitude(n1) > den1 || magnitude(n2) > den2) ok = 0;
    if (!ok) return r;
    s1 = floor_root(den1 * den1 - magnitude(n1) * magnitude(n1));
    s2 = floor_root(den2 * den2 - magnitude(n2) * magnitude(n2));
    elev = cordic_angle(z, x);
    a1 = to_q13(elev - cordic_angle(longint'(s1), n1));
    a2 = to_q13(cordic_angle(longint'(s2), -n2));
    r.ok = 1'b1;
    r.a1 = 16'(clamp(a1, a1_lo, a1_hi));
    r.a2 = 16'(clamp(a2, a2_lo, a2_hi));
    return r;
  endfunction

  // Sender: a new target may be offered whenever the current one is taken or none is up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      target_x_i <= '0;
      target_z_i <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (pending_targets.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        target_x_i <= pending_targets[0].x;
        target_z_i <= pending_targets[0].z;
        void'(pending_targets.pop_front());
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall, with an optional long hold-off to back the pipeline up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      long_hold_seen <= 0;
      long_hold_left <= 0;
    end else if (long_hold_req != long_hold_seen) begin
      long_hold_seen <= long_hold_req;
      long_hold_left <= 400;
      out_stall_i <= 1'b1;
    end else begin
      if (long_hold_left > 0) long_hold_left <= long_hold_left - 1;
      out_stall_i <= (long_hold_left > 1) || ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Shadow registers, prediction on input transactions, checks on output transactions.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link1_len <= 15'd12288;
      link2_len <= 15'd6144;
      a1_lo <= -16'sd25736;
      a1_hi <= 16'sd25736;
      a2_lo <= -16'sd25736;
      a2_hi <= 16'sd25736;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_FIRST_LEN:  link1_len <= cfg_data_i[14:0];
          REG_SECOND_LEN: link2_len <= cfg_data_i[14:0];
          REG_FIRST_MIN:  a1_lo <= cfg_data_i;
          REG_FIRST_MAX:  a1_hi <= cfg_data_i;
          REG_SECOND_MIN: a2_lo <= cfg_data_i;
          REG_SECOND_MAX: a2_hi <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        expected_solutions.push_back(solve_arm('{x: target_x_i, z: target_z_i}));
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_solutions.size() == 0) begin
          $display("%0t: unexpected result ok=%0b a1=%0d a2=%0d", $time,
                   solution_ok_o, first_angle_o, second_angle_o);
          fail_count++;
        end else begin
          if (solution_ok_o !== expected_solutions[0].ok) begin
            $display("%0t: solution_ok expected %0b actual %0b", $time,
                     expected_solutions[0].ok, solution_ok_o);
            fail_count++;
          end
          if (first_angle_o !== expected_solutions[0].a1) begin
            $display("%0t: first_angle expected %0d actual %0d", $time,
                     expected_solutions[0].a1, first_angle_o);
            fail_count++;
          end
          if (second_angle_o !== expected_solutions[0].a2) begin
            $display("%0t: second_angle expected %0d actual %0d", $time,
                     expected_solutions[0].a2, second_angle_o);
            fail_count++;
          end
          void'(expected_solutions.pop_front());
        end
      end
    end
  end

  // Watchdog: only counts while work is outstanding.
  always @(posedge clk_i) begin
    if ((pending_targets.size() > 0 || expected_solutions.size() > 0 || in_valid_i)
        && !(in_valid_i && !in_stall_o) && !(out_valid_o && !out_stall_i)) begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("two_link_inverse_kinematics_unit_test NOT OK");
        $finish;
      end
    end else begin
      stuck_cycles = 0;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_targets.size() > 0 || in_valid_i || expected_solutions.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_config(int l1, int l2, int lo1, int hi1, int lo2, int hi2);
    write_reg(REG_FIRST_LEN, 16'(l1));
    write_reg(REG_SECOND_LEN, 16'(l2));
    write_reg(REG_FIRST_MIN, 16'(lo1));
    write_reg(REG_FIRST_MAX, 16'(hi1));
    write_reg(REG_SECOND_MIN, 16'(lo2));
    write_reg(REG_SECOND_MAX, 16'(hi2));
  endtask

  // Mostly targets of any value, some near the origin, some near the reach limits.
  task automatic queue_random_targets(int count);
    target_t tg;
    int      sel, rad;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        tg.x = 16'($urandom);
        tg.z = 16'($urandom);
      end else if (sel < 8) begin
        tg.x = 16'($signed($urandom_range(0, 4095)) - 2048);
        tg.z = 16'($signed($urandom_range(0, 4095)) - 2048);
      end else begin
        rad = (sel == 8) ? int'(link1_len) + int'(link2_len) : int'(link1_len) - int'(link2_len);
        rad = rad + $signed($urandom_range(0, 8)) - 4;
        if (rad > 32767) rad = 32767;
        if (rad < -32768) rad = -32768;
        tg.x = $urandom_range(0, 1) ? 16'(rad) : 16'(-rad);
        tg.z = 16'($signed($urandom_range(0, 6)) - 3);
      end
      pending_targets.push_back(tg);
    end
  endtask

  initial begin
    target_t directed[$];
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    send_idle_pct = 17;
    recv_idle_pct = 79;
    long_hold_req = 0;
    fail_count = 0;
    stuck_cycles = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corners: origin, full-scale, exact outer and inner reach, tiny targets, behind the base.
    directed = '{'{0, 0}, '{32767, 32767}, '{-32768, -32768}, '{-32768, 0}, '{0, -32768},
                 '{32767, -32768}, '{18432, 0}, '{18433, 0}, '{6144, 0}, '{6143, 0},
                 '{0, 18432}, '{0, -6144}, '{-18432, 0}, '{-6144, 0}, '{1, 0}, '{0, 1},
                 '{-1, -1}, '{12288, 6144}, '{-12288, 6144}, '{-12288, -6144},
                 '{9000, -9000}, '{0, 12000}};
    foreach (directed[i]) pending_targets.push_back(directed[i]);
    wait_drained();

    queue_random_targets(380);
    wait_drained();

    // Longest and shortest links with narrow limits.
    load_config(32767, 1, -1000, 2000, 100, 300);
    pending_targets.push_back('{32767, 0});
    pending_targets.push_back('{-32768, 1});
    queue_random_targets(380);
    wait_drained();

    // Swapped lengths and crossed limits; the pipeline is pushed into backpressure here.
    send_idle_pct = 79;
    recv_idle_pct = 17;
    load_config(1, 32767, 25736, -25736, 3000, -3000);
    long_hold_req++;
    queue_random_targets(380);
    wait_drained();

    // Zero first length through the masked top bit, plus writes to unused indexes, then a zero second length.
    load_config(16'h8000, 6144, -25736, 25736, -25736, 25736);
    write_reg(cfg_reg_e'(3'd6), 16'hFFFF);
    write_reg(cfg_reg_e'(3'd7), 16'h0000);
    pending_targets.push_back('{12288, 0});
    queue_random_targets(40);
    wait_drained();
    load_config(12288, 0, -25736, 25736, -25736, 25736);
    queue_random_targets(40);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_config(8192, 8192, -25736, 25736, -25736, 25736);
    queue_random_targets(380);
    wait_drained();
    load_config(20000, 5000, 0, 25736, -25736, 0);
    long_hold_req++;
    queue_random_targets(300);
    wait_drained();

    if (fail_count == 0) begin
      $display("two_link_inverse_kinematics_unit_test OK");
    end else begin
      $display("two_link_inverse_kinematics_unit_test NOT OK");
    end
    $finish;
  end

endmodule
